// ===== design/markup_token_lexer_assert.svh =====
// ----------------------------------------------------------------------------
// Markup token lexer assertion macros
// Concurrent assertion helpers used by the lexer's top-level RTL file.
// ----------------------------------------------------------------------------
`ifndef MARKUP_TOKEN_LEXER_ASSERT_SVH
`define MARKUP_TOKEN_LEXER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MTL_ASSERT_IMPLIES(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Checks a condition in the cycle after a reset cycle.
`define MTL_ASSERT_AFTER_RESET(name, clk, rst_n, cons, msg) \
    name: assert property (@(posedge clk) (!rst_n) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/mtl_pkg.sv =====
// ----------------------------------------------------------------------------
// Markup token lexer package
// Types, character codes and the per-byte lexing functions.
// ----------------------------------------------------------------------------
`default_nettype none

package mtl_pkg;

    typedef enum logic [3:0] {
        MODE_IDLE  = 4'd0,
        MODE_LINE  = 4'd1,
        MODE_BLOCK = 4'd2,
        MODE_BARE  = 4'd3,
        MODE_NEG   = 4'd4,
        MODE_STR   = 4'd5,
        MODE_SUF   = 4'd6
    } t_mode;

    localparam logic [1:0] KIND_SCALAR = 2'd0;
    localparam logic [1:0] KIND_STRING = 2'd1;
    localparam logic [1:0] KIND_PUNCT  = 2'd2;

    localparam int MAX_EVENTS = 5;
    localparam int EV_CNT_W   = 3;
    localparam int LEX_PASSES = 3;

    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_DASH   = 8'h2D;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_EQUALS = 8'h3D;
    localparam logic [7:0] CH_UP_A   = 8'h41;
    localparam logic [7:0] CH_UP_Z   = 8'h5A;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_USCORE = 8'h5F;
    localparam logic [7:0] CH_LO_A   = 8'h61;
    localparam logic [7:0] CH_LO_N   = 8'h6E;
    localparam logic [7:0] CH_LO_R   = 8'h72;
    localparam logic [7:0] CH_LO_T   = 8'h74;
    localparam logic [7:0] CH_LO_Z   = 8'h7A;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;

    typedef struct packed {
        logic       err;
        logic       done;
        logic       tok_end;
        logic       tok_start;
        logic       suffix;
        logic [1:0] kind;
        logic [7:0] data;
        logic       has;
    } t_event;

    typedef struct packed {
        logic [EV_CNT_W-1:0]         count;
        t_event [MAX_EVENTS-1:0]     ev;
    } t_entry;

    typedef struct packed {
        t_mode mode;
        logic  held_slash;
        logic  held_dash;
        logic  escape;
        logic  star;
    } t_lex_state;

    typedef struct packed {
        t_lex_state st;
        t_event     ev0;
        t_event     ev1;
        logic [1:0] count;
        logic       again;
    } t_pass;

    localparam t_lex_state LEX_RESET = '{MODE_IDLE, 1'b0, 1'b0, 1'b0, 1'b0};

    function automatic t_event ev_make(logic has, logic [7:0] data, logic [1:0] kind,
                                       logic suffix, logic start, logic tok_end,
                                       logic done, logic err);
        t_event e;
        e.has       = has;
        e.data      = has ? data : 8'h00;
        e.kind      = kind;
        e.suffix    = suffix;
        e.tok_start = start;
        e.tok_end   = tok_end;
        e.done      = done;
        e.err       = err;
        return e;
    endfunction

    function automatic logic is_space(logic [7:0] c);
        return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function automatic logic is_punct(logic [7:0] c);
        return (c == CH_LBRACE) || (c == CH_RBRACE) || (c == CH_LBRACK) ||
               (c == CH_RBRACK) || (c == CH_LPAREN) || (c == CH_RPAREN) ||
               (c == CH_EQUALS);
    endfunction

    function automatic logic is_digit(logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    function automatic logic is_word(logic [7:0] c);
        return is_digit(c) || (c >= CH_LO_A && c <= CH_LO_Z) ||
               (c >= CH_UP_A && c <= CH_UP_Z) || (c == CH_USCORE);
    endfunction

    function automatic logic ends_scalar(logic [7:0] c, logic dash_ends);
        return is_space(c) || (c == CH_COMMA) || (c == CH_HASH) || (c == CH_QUOTE) ||
               is_punct(c) || (dash_ends && (c == CH_DASH));
    endfunction

    function automatic t_pass pass_emit(t_pass p, t_event e);
        t_pass r;
        r = p;
        if (r.count == 2'd0) begin
            r.ev0 = e;
        end else begin
            r.ev1 = e;
        end
        r.count = r.count + 2'd1;
        return r;
    endfunction

    // One pass of the lexer over a byte. When again is set, the same byte has
    // to be looked at once more in the new mode.
    function automatic t_pass lex_pass(t_lex_state st, logic [7:0] c);
        t_pass  r;
        logic   closed;
        logic [7:0] dec;
        r       = '0;
        r.st    = st;
        closed  = 1'b0;
        dec     = c;
        unique case (st.mode)
            MODE_LINE: begin
                if (c == CH_LF) r.st.mode = MODE_IDLE;
            end
            MODE_BLOCK: begin
                if (st.star && c == CH_SLASH) begin
                    r.st.star = 1'b0;
                    r.st.mode = MODE_IDLE;
                end else begin
                    r.st.star = (c == CH_STAR);
                end
            end
            MODE_BARE, MODE_NEG: begin
                if (st.held_slash) begin
                    r.st.held_slash = 1'b0;
                    if (c == CH_SLASH || c == CH_STAR) begin
                        r = pass_emit(r, ev_make(1'b0, 8'h00, KIND_SCALAR,
                                                 1'b0, 1'b0, 1'b1, 1'b0, 1'b0));
                        r.st.star = 1'b0;
                        r.st.mode = (c == CH_SLASH) ? MODE_LINE : MODE_BLOCK;
                        closed    = 1'b1;
                    end else begin
                        r = pass_emit(r, ev_make(1'b1, CH_SLASH, KIND_SCALAR,
                                                 1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
                    end
                end
                if (!closed) begin
                    if (ends_scalar(c, st.mode == MODE_BARE)) begin
                        r = pass_emit(r, ev_make(1'b0, 8'h00, KIND_SCALAR,
                                                 1'b0, 1'b0, 1'b1, 1'b0, 1'b0));
                        r.st.mode = MODE_IDLE;
                        r.again   = 1'b1;
                    end else if (c == CH_SLASH) begin
                        r.st.held_slash = 1'b1;
                    end else begin
                        r = pass_emit(r, ev_make(1'b1, c, KIND_SCALAR,
                                                 1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
                    end
                end
            end
            MODE_STR: begin
                if (st.escape) begin
                    if (c == CH_LO_N) begin
                        dec = CH_LF;
                    end else if (c == CH_LO_R) begin
                        dec = CH_CR;
                    end else if (c == CH_LO_T) begin
                        dec = CH_TAB;
                    end
                    r.st.escape = 1'b0;
                    r = pass_emit(r, ev_make(1'b1, dec, KIND_STRING,
                                             1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
                end else if (c == CH_BSLASH) begin
                    r.st.escape = 1'b1;
                end else if (c == CH_QUOTE) begin
                    r.st.mode = MODE_SUF;
                end else begin
                    r = pass_emit(r, ev_make(1'b1, c, KIND_STRING,
                                             1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
                end
            end
            MODE_SUF: begin
                if (is_word(c)) begin
                    r = pass_emit(r, ev_make(1'b1, c, KIND_STRING,
                                             1'b1, 1'b0, 1'b0, 1'b0, 1'b0));
                end else begin
                    r = pass_emit(r, ev_make(1'b0, 8'h00, KIND_STRING,
                                             1'b0, 1'b0, 1'b1, 1'b0, 1'b0));
                    r.st.mode = MODE_IDLE;
                    r.again   = 1'b1;
                end
            end
            default: begin
                r.st.mode = MODE_IDLE;
                if (st.held_slash) begin
                    r.st.held_slash = 1'b0;
                    if (c == CH_SLASH || c == CH_STAR) begin
                        r.st.star = 1'b0;
                        r.st.mode = (c == CH_SLASH) ? MODE_LINE : MODE_BLOCK;
                    end else begin
                        r = pass_emit(r, ev_make(1'b1, CH_SLASH, KIND_SCALAR,
                                                 1'b0, 1'b1, 1'b0, 1'b0, 1'b0));
                        r.st.mode = MODE_BARE;
                        r.again   = 1'b1;
                    end
                end else begin
                    if (st.held_dash) begin
                        r.st.held_dash = 1'b0;
                        if (is_digit(c)) begin
                            r = pass_emit(r, ev_make(1'b1, CH_DASH, KIND_SCALAR,
                                                     1'b0, 1'b1, 1'b0, 1'b0, 1'b0));
                            r.st.mode = MODE_NEG;
                            r.again   = 1'b1;
                            closed    = 1'b1;
                        end else begin
                            r = pass_emit(r, ev_make(1'b1, CH_DASH, KIND_PUNCT,
                                                     1'b0, 1'b1, 1'b1, 1'b0, 1'b0));
                        end
                    end
                    if (!closed) begin
                        priority if (is_space(c) || c == CH_COMMA) begin
                            r.st.mode = MODE_IDLE;
                        end else if (c == CH_HASH) begin
                            r.st.mode = MODE_LINE;
                        end else if (c == CH_SLASH) begin
                            r.st.held_slash = 1'b1;
                        end else if (c == CH_DASH) begin
                            r.st.held_dash = 1'b1;
                        end else if (is_punct(c)) begin
                            r = pass_emit(r, ev_make(1'b1, c, KIND_PUNCT,
                                                     1'b0, 1'b1, 1'b1, 1'b0, 1'b0));
                        end else if (c == CH_QUOTE) begin
                            r = pass_emit(r, ev_make(1'b0, 8'h00, KIND_STRING,
                                                     1'b0, 1'b1, 1'b0, 1'b0, 1'b0));
                            r.st.escape = 1'b0;
                            r.st.mode   = MODE_STR;
                        end else begin
                            r = pass_emit(r, ev_make(1'b1, c, KIND_SCALAR,
                                                     1'b0, 1'b1, 1'b0, 1'b0, 1'b0));
                            r.st.mode = MODE_BARE;
                        end
                    end
                end
            end
        endcase
        return r;
    endfunction

    function automatic t_entry entry_append(t_entry en, t_event e);
        t_entry r;
        r = en;
        if (r.count < EV_CNT_W'(MAX_EVENTS)) begin
            r.ev[r.count] = e;
            r.count       = r.count + EV_CNT_W'(1);
        end
        return r;
    endfunction

    // Flushes whatever is held or open at the end of the text and adds the
    // closing event.
    function automatic t_entry entry_finish(t_entry en, t_lex_state st);
        t_entry r;
        logic   err;
        r   = en;
        err = 1'b0;
        unique case (st.mode)
            MODE_BARE, MODE_NEG: begin
                if (st.held_slash) begin
                    r = entry_append(r, ev_make(1'b1, CH_SLASH, KIND_SCALAR,
                                                1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
                end
                r = entry_append(r, ev_make(1'b0, 8'h00, KIND_SCALAR,
                                            1'b0, 1'b0, 1'b1, 1'b0, 1'b0));
            end
            MODE_STR, MODE_SUF: begin
                r = entry_append(r, ev_make(1'b0, 8'h00, KIND_STRING,
                                            1'b0, 1'b0, 1'b1, 1'b0, 1'b0));
            end
            MODE_LINE: begin
                err = 1'b0;
            end
            MODE_BLOCK: begin
                err = 1'b1;
            end
            default: begin
                if (st.held_slash) begin
                    r = entry_append(r, ev_make(1'b1, CH_SLASH, KIND_SCALAR,
                                                1'b0, 1'b1, 1'b0, 1'b0, 1'b0));
                    r = entry_append(r, ev_make(1'b0, 8'h00, KIND_SCALAR,
                                                1'b0, 1'b0, 1'b1, 1'b0, 1'b0));
                end else if (st.held_dash) begin
                    r = entry_append(r, ev_make(1'b1, CH_DASH, KIND_PUNCT,
                                                1'b0, 1'b1, 1'b1, 1'b0, 1'b0));
                end
            end
        endcase
        r = entry_append(r, ev_make(1'b0, 8'h00, KIND_SCALAR,
                                    1'b0, 1'b0, 1'b0, 1'b1, err));
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== design/markup_token_lexer.sv =====
// ----------------------------------------------------------------------------
// Markup token lexer
// Streaming lexer for a brace and bracket markup language.
// ----------------------------------------------------------------------------
// The block takes one text byte per transfer and can accept a byte in every
// cycle. Each byte yields between zero and five token events, which are held
// as one group in a queue of P_QUEUE_DEPTH groups and leave the block at one
// event per cycle through a registered output; the sustained rate is thus set
// by the output port, one event per cycle, and the input stalls only when the
// queue is full. A byte flagged with s_tlast closes the text: open tokens are
// flushed, a final event with m_tlast follows, and the lexer returns to its
// reset state for the next text.
`default_nettype none
`include "markup_token_lexer_assert.svh"

module markup_token_lexer
    import mtl_pkg::*;
#(
    parameter int P_QUEUE_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] text_byte
    input  logic        s_tlast,   // end_of_text
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [0] has_byte, [8:1] out_byte, [9] in_suffix,
                                   // [10] token_start, [11] token_end,
                                   // [12] open_comment_error, [15:13] zero
    output logic [1:0]  m_tuser,   // [1:0] token_kind
    output logic        m_tlast    // stream_done
);

    localparam int ENTRY_W = $bits(t_entry);

    logic               q_push;
    logic               q_full;
    logic               q_valid;
    logic               q_pop;
    t_entry             f_entry;
    logic [ENTRY_W-1:0] q_data;
    t_event             out_ev;

    mtl_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_tvalid),
        .i_byte  (s_tdata),
        .i_last  (s_tlast),
        .o_ready (s_tready),
        .i_full  (q_full),
        .o_push  (q_push),
        .o_entry (f_entry)
    );

    mtl_queue #(
        .WIDTH (ENTRY_W),
        .DEPTH (P_QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (f_entry),
        .o_full  (q_full),
        .o_valid (q_valid),
        .i_pop   (q_pop),
        .o_data  (q_data)
    );

    mtl_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .i_entry (t_entry'(q_data)),
        .o_pop   (q_pop),
        .o_valid (m_tvalid),
        .i_ready (m_tready),
        .o_event (out_ev)
    );

    assign m_tdata = {3'b000, out_ev.err, out_ev.tok_end, out_ev.tok_start,
                      out_ev.suffix, out_ev.data, out_ev.has};
    assign m_tuser = out_ev.kind;
    assign m_tlast = out_ev.done;

    `MTL_ASSERT_IMPLIES(a_err_only_at_done, i_clk, i_rst_n, m_tvalid && m_tdata[12], m_tlast, "comment error outside the closing event")
    `MTL_ASSERT_IMPLIES(a_done_is_bare, i_clk, i_rst_n, m_tvalid && m_tlast, !m_tdata[0] && (m_tuser == KIND_SCALAR), "closing event carries a byte or a kind")
    `MTL_ASSERT_IMPLIES(a_byteless_zero, i_clk, i_rst_n, m_tvalid && !m_tdata[0], m_tdata[8:1] == 8'h00, "byteless event with a nonzero byte")
    `MTL_ASSERT_AFTER_RESET(a_reset_quiet, i_clk, i_rst_n, !m_tvalid && s_tready, "output busy or input blocked after reset")

endmodule

`default_nettype wire

// ===== design/mtl_front.sv =====
// ----------------------------------------------------------------------------
// Markup token lexer front end
// Accepts text bytes, runs the lexer state and queues each byte's events.
// ----------------------------------------------------------------------------
`default_nettype none

module mtl_front
    import mtl_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [7:0] i_byte,
    input  logic       i_last,
    output logic       o_ready,
    input  logic       i_full,
    output logic       o_push,
    output t_entry     o_entry
);

    t_lex_state r_state;
    t_lex_state n_state;
    t_entry     n_entry;
    t_pass      pass;
    logic       go;
    logic       accept;

    always_comb begin
        n_state = r_state;
        n_entry = '0;
        pass    = '0;
        go      = 1'b1;
        for (int k = 0; k < LEX_PASSES; k++) begin
            if (go) begin
                pass    = lex_pass(n_state, i_byte);
                n_state = pass.st;
                go      = pass.again;
                if (pass.count != 2'd0) n_entry = entry_append(n_entry, pass.ev0);
                if (pass.count == 2'd2) n_entry = entry_append(n_entry, pass.ev1);
            end
        end
        if (i_last) begin
            n_entry = entry_finish(n_entry, n_state);
            n_state = LEX_RESET;
        end
    end

    assign o_ready = !i_full;
    assign accept  = i_valid && o_ready;
    assign o_push  = accept && (n_entry.count != '0);
    assign o_entry = n_entry;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= LEX_RESET;
        end else if (accept) begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

// ===== design/mtl_queue.sv =====
// ----------------------------------------------------------------------------
// Markup token lexer event queue
// Small first-in first-out buffer between the front and back ends.
// ----------------------------------------------------------------------------
`default_nettype none

module mtl_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    output logic             o_valid,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data
);

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [IDX_W-1:0] r_wr;
    logic [IDX_W-1:0] r_rd;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        unique case ({do_push, do_pop})
            2'b10:   n_count = r_count + CNT_W'(1);
            2'b01:   n_count = r_count - CNT_W'(1);
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_count <= n_count;
            if (do_push) begin
                r_wr <= (r_wr == IDX_W'(DEPTH - 1)) ? '0 : r_wr + IDX_W'(1);
            end
            if (do_pop) begin
                r_rd <= (r_rd == IDX_W'(DEPTH - 1)) ? '0 : r_rd + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

`default_nettype wire

// ===== design/mtl_back.sv =====
// ----------------------------------------------------------------------------
// Markup token lexer back end
// Unpacks queued event groups and presents one event per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

module mtl_back
    import mtl_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_valid,
    input  t_entry i_entry,
    output logic   o_pop,
    output logic   o_valid,
    input  logic   i_ready,
    output t_event o_event
);

    logic                r_busy;
    t_entry              r_entry;
    logic [EV_CNT_W-1:0] r_idx;
    logic                r_out_valid;
    t_event              r_out_event;
    logic                load_out;
    logic                last;

    assign load_out = r_busy && (!r_out_valid || i_ready);
    assign last     = (r_idx == (r_entry.count - EV_CNT_W'(1)));
    assign o_pop    = i_valid && (!r_busy || (load_out && last));
    assign o_valid  = r_out_valid;
    assign o_event  = r_out_event;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_busy <= 1'b1;
                r_idx  <= '0;
            end else if (load_out && last) begin
                r_busy <= 1'b0;
            end else if (load_out) begin
                r_idx <= r_idx + EV_CNT_W'(1);
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_entry <= i_entry;
        end
        if (load_out) begin
            r_out_event <= r_entry.ev[r_idx];
        end
    end

endmodule

`default_nettype wire
